### hdl/sdpf_pkg.sv
package sdpf_pkg;

  // Default capacity of the particle store
  localparam int MAX_PARTICLES_DEF = 64;

  // Fixed port widths
  localparam int PIDX_W = 6;
  localparam int POS_W  = 32;
  localparam int REG_W  = 31;

  // Working magnitudes are 48 bits, signed values 49 bits (range +-2^47)
  localparam int MAG_W = 48;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic signed [MAG_W:0]   sfix_t;
  typedef logic [2*MAG_W-1:0]      prod_t;

  localparam mag_t  LIM   = 48'h8000_0000_0000;
  localparam mag_t  K6PI  = 48'd125165;
  localparam mag_t  K12PI = 48'd250329;
  localparam sfix_t ONE   = 49'sd65536;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_COMPUTE = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_TARGET = 2'd1,
    REG_GAIN   = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_R2, ST_I_RD, ST_I_CAP, ST_PI, ST_J_RD, ST_OFF, ST_SQ, ST_CMP,
    ST_SQRT, ST_Q, ST_K0, ST_K1, ST_K2, ST_K3, ST_DIR, ST_S0, ST_SDIV, ST_PJ,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_NEXT_J, ST_DWR, ST_ACC, ST_EMIT
  } state_t;

  // Magnitude of a signed working value
  function automatic mag_t mag_of(sfix_t v);
    sfix_t a;
    a = v[MAG_W] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // Attach a sign to a magnitude
  function automatic sfix_t with_sign(mag_t m, logic neg);
    sfix_t s;
    s = sfix_t'({1'b0, m});
    return neg ? -s : s;
  endfunction

  // Drop 16 fraction bits of a full product and saturate
  function automatic mag_t qprod(prod_t p);
    return (|p[2*MAG_W-1:MAG_W+15]) ? LIM : {1'b0, p[MAG_W+14:16]};
  endfunction

  // Saturating add
  function automatic sfix_t sat_add(sfix_t a, sfix_t b);
    logic signed [MAG_W+1:0] s;
    logic signed [MAG_W+1:0] lim;
    logic signed [MAG_W+1:0] nlim;
    s    = $signed({a[MAG_W], a}) + $signed({b[MAG_W], b});
    lim  = $signed({2'b00, LIM});
    nlim = -lim;
    if (s > lim) begin
      return lim[MAG_W:0];
    end else if (s < nlim) begin
      return nlim[MAG_W:0];
    end
    return s[MAG_W:0];
  endfunction

  // Average of two values, truncated toward zero
  function automatic sfix_t half_sum(sfix_t a, sfix_t b);
    logic signed [MAG_W+1:0] s;
    logic signed [MAG_W+1:0] h;
    s = $signed({a[MAG_W], a}) + $signed({b[MAG_W], b});
    if (s[MAG_W+1]) begin
      s = s + 50'sd1;
    end
    h = s >>> 1;
    return h[MAG_W:0];
  endfunction

  // Clamp to the 32-bit output range
  function automatic logic [31:0] clamp32(sfix_t v);
    if (v > $signed(49'h0_0000_7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end else if (v < $signed(49'h1_FFFF_8000_0000)) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

### hdl/sph_density_pressure_force_core.sv
// Channel   Handshake                  Words
// command   start / busy               action, pos_x, pos_y, pos_z, particle_mass
// result    result_valid (no stall)    particle_index, density, accel_x/y/z, last
// config    APB psel/penable, pready=1 smoothing_radius, target_density, pressure_gain
//
// Load and clear complete in idle without leaving it; loads may follow back to back.
// A compute run walks every particle pair twice through one multiplier,
// one divider (one quotient bit per cycle) and one square root unit; a pair
// with an axis offset at or beyond the radius is dropped before any square
// is taken, one outside only on distance once the squared sum is compared.
// busy stays high for the whole run.
// Reset is synchronous; no clearing pass. Results cannot be stalled.
module sph_density_pressure_force_core #(
  parameter int MAX_PARTICLES = sdpf_pkg::MAX_PARTICLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [30:0]        particle_mass,
  output logic               result_valid,
  output logic [5:0]         particle_index,
  output logic [30:0]        density,
  output logic signed [31:0] accel_x,
  output logic signed [31:0] accel_y,
  output logic signed [31:0] accel_z,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  sdpf_pkg::state_t state;
  sdpf_pkg::state_t state_next;

  // Configuration
  logic [30:0] radius;
  logic [30:0] target;
  logic [30:0] gain;

  // Control
  logic          launched;
  logic          pass;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [1:0]    ax;
  logic [CW-1:0] count;
  logic [IW-1:0] raddr;
  logic          last_i;
  logic          last_j;

  // Particle store
  logic [31:0] mem_x [MAX_PARTICLES];
  logic [31:0] mem_y [MAX_PARTICLES];
  logic [31:0] mem_z [MAX_PARTICLES];
  logic [30:0] mem_m [MAX_PARTICLES];
  logic [30:0] mem_d [MAX_PARTICLES];
  logic [31:0] rd_x;
  logic [31:0] rd_y;
  logic [31:0] rd_z;
  logic [30:0] rd_m;
  logic [30:0] rd_d;
  logic        load_we;

  // Datapath
  logic signed [31:0] xi;
  logic signed [31:0] yi;
  logic signed [31:0] zi;
  logic [30:0]        den_i;
  sdpf_pkg::sfix_t    p_i;
  logic signed [32:0] off [3];
  logic [31:0]        au [3];
  logic signed [32:0] off_c [3];
  logic [31:0]        au_c [3];
  logic               skip;
  logic [63:0]        sum;
  logic [61:0]        r2;
  logic [30:0]        d;
  logic [16:0]        q;
  sdpf_pkg::sfix_t    t;
  logic [53:0]        acc;
  sdpf_pkg::mag_t     slope;
  sdpf_pkg::sfix_t    shared;
  sdpf_pkg::sfix_t    dir [3];
  sdpf_pkg::sfix_t    frc [3];
  logic [31:0]        accel [3];
  logic signed [31:0] err_i;
  logic signed [31:0] err_j;
  logic [31:0]        err_i_mag;
  logic [31:0]        err_j_mag;

  // Shared units
  logic            mul_go;
  logic            div_go;
  logic            sqrt_go;
  logic            mul_start;
  logic            div_start;
  logic            sqrt_start;
  logic            mul_done;
  logic            div_done;
  logic            sqrt_done;
  sdpf_pkg::mag_t  mul_a;
  sdpf_pkg::mag_t  mul_b;
  sdpf_pkg::prod_t mul_p;
  sdpf_pkg::mag_t  div_n;
  sdpf_pkg::mag_t  div_d;
  sdpf_pkg::mag_t  div_q;
  logic [31:0]     sq_root;

  sdpf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  sdpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (div_q)
  );

  sdpf_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (sum),
    .done  (sqrt_done),
    .root  (sq_root)
  );

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 31'd65536;
      target <= 31'd65536;
      gain   <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        sdpf_pkg::REG_RADIUS: radius <= pwdata[30:0];
        sdpf_pkg::REG_TARGET: target <= pwdata[30:0];
        sdpf_pkg::REG_GAIN:   gain   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sdpf_pkg::REG_RADIUS: prdata = {1'b0, radius};
      sdpf_pkg::REG_TARGET: prdata = {1'b0, target};
      sdpf_pkg::REG_GAIN:   prdata = {1'b0, gain};
      default:              prdata = '0;
    endcase
  end

  // Loop bounds and pair geometry
  assign last_i = (CW'(i) + CW'(1)) == count;
  assign last_j = (CW'(j) + CW'(1)) == count;
  assign load_we = (state == sdpf_pkg::ST_IDLE) && start && (action == sdpf_pkg::ACT_LOAD)
                   && (count < CW'(MAX_PARTICLES));

  assign off_c[0] = $signed({xi[31], xi}) - $signed({rd_x[31], rd_x});
  assign off_c[1] = $signed({yi[31], yi}) - $signed({rd_y[31], rd_y});
  assign off_c[2] = $signed({zi[31], zi}) - $signed({rd_z[31], rd_z});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      au_c[k] = off_c[k][32] ? 32'(-off_c[k]) : off_c[k][31:0];
    end
  end

  assign skip = (pass && (i == j)) || (au_c[0] >= {1'b0, radius})
                || (au_c[1] >= {1'b0, radius}) || (au_c[2] >= {1'b0, radius});

  assign err_i = $signed({1'b0, den_i}) - $signed({1'b0, target});
  assign err_j = $signed({1'b0, rd_d}) - $signed({1'b0, target});
  assign err_i_mag = err_i[31] ? 32'(-err_i) : err_i;
  assign err_j_mag = err_j[31] ? 32'(-err_j) : err_j;

  // Particle store: written on load and at the end of each density row
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_x[count[IW-1:0]] <= pos_x;
      mem_y[count[IW-1:0]] <= pos_y;
      mem_z[count[IW-1:0]] <= pos_z;
      mem_m[count[IW-1:0]] <= particle_mass;
    end
    if (state == sdpf_pkg::ST_DWR) begin
      mem_d[i] <= (acc > 54'h7FFF_FFFF) ? 31'h7FFF_FFFF : acc[30:0];
    end
    rd_x <= mem_x[raddr];
    rd_y <= mem_y[raddr];
    rd_z <= mem_z[raddr];
    rd_m <= mem_m[raddr];
    rd_d <= mem_d[raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sdpf_pkg::ST_IDLE:
        if (start && (action == sdpf_pkg::ACT_COMPUTE) && (count != '0)) begin
          state_next = sdpf_pkg::ST_R2;
        end
      sdpf_pkg::ST_R2:    if (mul_done) state_next = sdpf_pkg::ST_I_RD;
      sdpf_pkg::ST_I_RD:  state_next = sdpf_pkg::ST_I_CAP;
      sdpf_pkg::ST_I_CAP: state_next = pass ? sdpf_pkg::ST_PI : sdpf_pkg::ST_J_RD;
      sdpf_pkg::ST_PI:    if (mul_done) state_next = sdpf_pkg::ST_J_RD;
      sdpf_pkg::ST_J_RD:  state_next = sdpf_pkg::ST_OFF;
      sdpf_pkg::ST_OFF:   state_next = skip ? sdpf_pkg::ST_NEXT_J : sdpf_pkg::ST_SQ;
      sdpf_pkg::ST_SQ:    if (mul_done && ax == 2'd2) state_next = sdpf_pkg::ST_CMP;
      sdpf_pkg::ST_CMP:
        state_next = (sum >= {2'b00, r2}) ? sdpf_pkg::ST_NEXT_J : sdpf_pkg::ST_SQRT;
      sdpf_pkg::ST_SQRT:  if (sqrt_done) state_next = sdpf_pkg::ST_Q;
      sdpf_pkg::ST_Q:
        if (div_done) state_next = pass ? sdpf_pkg::ST_DIR : sdpf_pkg::ST_K0;
      sdpf_pkg::ST_K0:    if (mul_done) state_next = sdpf_pkg::ST_K1;
      sdpf_pkg::ST_K1:    if (mul_done) state_next = sdpf_pkg::ST_K2;
      sdpf_pkg::ST_K2:    if (div_done) state_next = sdpf_pkg::ST_K3;
      sdpf_pkg::ST_K3:    if (div_done) state_next = sdpf_pkg::ST_NEXT_J;
      sdpf_pkg::ST_DIR:
        if ((d == '0) || (div_done && ax == 2'd2)) state_next = sdpf_pkg::ST_S0;
      sdpf_pkg::ST_S0:    if (mul_done) state_next = sdpf_pkg::ST_SDIV;
      sdpf_pkg::ST_SDIV:  if (div_done && ax == 2'd2) state_next = sdpf_pkg::ST_PJ;
      sdpf_pkg::ST_PJ:    if (mul_done) state_next = sdpf_pkg::ST_T0;
      sdpf_pkg::ST_T0:    if (mul_done) state_next = sdpf_pkg::ST_T1;
      sdpf_pkg::ST_T1:    if (mul_done) state_next = sdpf_pkg::ST_T2;
      sdpf_pkg::ST_T2:    if (mul_done) state_next = sdpf_pkg::ST_T3;
      sdpf_pkg::ST_T3:
        if (div_done) state_next = (ax == 2'd2) ? sdpf_pkg::ST_NEXT_J : sdpf_pkg::ST_T0;
      sdpf_pkg::ST_NEXT_J:
        if (last_j) begin
          state_next = pass ? sdpf_pkg::ST_ACC : sdpf_pkg::ST_DWR;
        end else begin
          state_next = sdpf_pkg::ST_J_RD;
        end
      sdpf_pkg::ST_DWR:   state_next = sdpf_pkg::ST_I_RD;
      sdpf_pkg::ST_ACC:   if (div_done && ax == 2'd2) state_next = sdpf_pkg::ST_EMIT;
      sdpf_pkg::ST_EMIT:  state_next = last_i ? sdpf_pkg::ST_IDLE : sdpf_pkg::ST_I_RD;
      default:            state_next = sdpf_pkg::ST_IDLE;
    endcase
  end

  // Unit operands and launches
  always_comb begin
    mul_go  = 1'b0;
    div_go  = 1'b0;
    sqrt_go = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = '0;
    unique case (state) inside
      sdpf_pkg::ST_R2: begin
        mul_go = 1'b1;
        mul_a  = 48'(radius);
        mul_b  = 48'(radius);
      end
      sdpf_pkg::ST_PI: begin
        mul_go = 1'b1;
        mul_a  = 48'(err_i_mag);
        mul_b  = 48'(gain);
      end
      sdpf_pkg::ST_SQ: begin
        mul_go = 1'b1;
        mul_a  = 48'(au[ax]);
        mul_b  = 48'(au[ax]);
      end
      sdpf_pkg::ST_SQRT: sqrt_go = 1'b1;
      sdpf_pkg::ST_Q: begin
        div_go = 1'b1;
        div_n  = 48'(radius - d);
        div_d  = 48'(radius);
      end
      sdpf_pkg::ST_K0: begin
        mul_go = 1'b1;
        mul_a  = 48'(q);
        mul_b  = 48'(q);
      end
      sdpf_pkg::ST_K1: begin
        mul_go = 1'b1;
        mul_a  = sdpf_pkg::K6PI;
        mul_b  = sdpf_pkg::mag_of(t);
      end
      sdpf_pkg::ST_K2, sdpf_pkg::ST_K3, sdpf_pkg::ST_SDIV: begin
        div_go = 1'b1;
        div_n  = sdpf_pkg::mag_of(t);
        div_d  = 48'(radius);
      end
      sdpf_pkg::ST_DIR: begin
        div_go = (d != '0);
        div_n  = 48'(au[ax]);
        div_d  = 48'(d);
      end
      sdpf_pkg::ST_S0: begin
        mul_go = 1'b1;
        mul_a  = sdpf_pkg::K12PI;
        mul_b  = 48'(q);
      end
      sdpf_pkg::ST_PJ: begin
        mul_go = 1'b1;
        mul_a  = 48'(err_j_mag);
        mul_b  = 48'(gain);
      end
      sdpf_pkg::ST_T0: begin
        mul_go = 1'b1;
        mul_a  = sdpf_pkg::mag_of(shared);
        mul_b  = sdpf_pkg::mag_of(dir[ax]);
      end
      sdpf_pkg::ST_T1: begin
        mul_go = 1'b1;
        mul_a  = sdpf_pkg::mag_of(t);
        mul_b  = slope;
      end
      sdpf_pkg::ST_T2: begin
        mul_go = 1'b1;
        mul_a  = sdpf_pkg::mag_of(t);
        mul_b  = 48'(rd_m);
      end
      sdpf_pkg::ST_T3: begin
        div_go = 1'b1;
        div_n  = sdpf_pkg::mag_of(t);
        div_d  = 48'(rd_d);
      end
      sdpf_pkg::ST_ACC: begin
        div_go = 1'b1;
        div_n  = sdpf_pkg::mag_of(frc[ax]);
        div_d  = 48'(den_i);
      end
      default: ;
    endcase
    mul_start    = mul_go & ~launched;
    div_start    = div_go & ~launched;
    sqrt_start   = sqrt_go & ~launched;
    busy         = (state != sdpf_pkg::ST_IDLE);
    result_valid = (state == sdpf_pkg::ST_EMIT);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sdpf_pkg::ST_IDLE;
      launched <= 1'b0;
      count    <= '0;
      pass     <= 1'b0;
      i        <= '0;
      j        <= '0;
      ax       <= '0;
      raddr    <= '0;
    end else begin
      state <= state_next;
      if (mul_start || div_start || sqrt_start) begin
        launched <= 1'b1;
      end else if (mul_done || div_done || sqrt_done) begin
        launched <= 1'b0;
      end
      // Step the axis counter in the per-axis loops
      if ((state == sdpf_pkg::ST_SQ && mul_done)
          || ((state == sdpf_pkg::ST_DIR || state == sdpf_pkg::ST_SDIV
               || state == sdpf_pkg::ST_T3 || state == sdpf_pkg::ST_ACC) && div_done)) begin
        ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
      end
      unique case (state)
        sdpf_pkg::ST_IDLE:
          if (start) begin
            case (action)
              sdpf_pkg::ACT_LOAD:    if (load_we) count <= count + CW'(1);
              sdpf_pkg::ACT_CLEAR:   count <= '0;
              sdpf_pkg::ACT_COMPUTE: begin
                pass  <= 1'b0;
                i     <= '0;
                raddr <= '0;
              end
              default: ;
            endcase
          end
        sdpf_pkg::ST_I_CAP: begin
          j     <= '0;
          raddr <= '0;
        end
        sdpf_pkg::ST_NEXT_J:
          if (!last_j) begin
            j     <= j + 1'b1;
            raddr <= j + 1'b1;
          end else begin
            raddr <= i;
          end
        sdpf_pkg::ST_DWR:
          if (last_i) begin
            pass  <= 1'b1;
            i     <= '0;
            raddr <= '0;
          end else begin
            i     <= i + 1'b1;
            raddr <= i + 1'b1;
          end
        sdpf_pkg::ST_EMIT:
          if (!last_i) begin
            i     <= i + 1'b1;
            raddr <= i + 1'b1;
          end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      sdpf_pkg::ST_R2: if (mul_done) r2 <= mul_p[61:0];
      sdpf_pkg::ST_I_CAP: begin
        xi    <= rd_x;
        yi    <= rd_y;
        zi    <= rd_z;
        den_i <= rd_d;
        acc   <= '0;
        for (int k = 0; k < 3; k++) begin
          frc[k] <= '0;
        end
      end
      sdpf_pkg::ST_PI:
        if (mul_done) p_i <= sdpf_pkg::with_sign(sdpf_pkg::qprod(mul_p), err_i[31]);
      sdpf_pkg::ST_OFF: begin
        off <= off_c;
        au  <= au_c;
        sum <= '0;
      end
      sdpf_pkg::ST_SQ:   if (mul_done) sum <= sum + mul_p[63:0];
      sdpf_pkg::ST_SQRT: if (sqrt_done) d <= sq_root[30:0];
      sdpf_pkg::ST_Q:    if (div_done) q <= div_q[16:0];
      sdpf_pkg::ST_K0, sdpf_pkg::ST_K1, sdpf_pkg::ST_S0:
        if (mul_done) t <= sdpf_pkg::with_sign(sdpf_pkg::qprod(mul_p), 1'b0);
      sdpf_pkg::ST_K2:   if (div_done) t <= sdpf_pkg::with_sign(div_q, 1'b0);
      sdpf_pkg::ST_K3:   if (div_done) acc <= acc + 54'(div_q);
      sdpf_pkg::ST_DIR:
        if (d == '0) begin
          dir[0] <= '0;
          dir[1] <= sdpf_pkg::ONE;
          dir[2] <= '0;
        end else if (div_done) begin
          dir[ax] <= sdpf_pkg::with_sign(div_q, off[ax][32]);
        end
      sdpf_pkg::ST_SDIV:
        if (div_done) begin
          t     <= sdpf_pkg::with_sign(div_q, 1'b0);
          slope <= div_q;
        end
      sdpf_pkg::ST_PJ:
        if (mul_done) begin
          shared <= sdpf_pkg::half_sum(p_i,
                      sdpf_pkg::with_sign(sdpf_pkg::qprod(mul_p), err_j[31]));
        end
      sdpf_pkg::ST_T0:
        if (mul_done) begin
          t <= sdpf_pkg::with_sign(sdpf_pkg::qprod(mul_p),
                                   shared[sdpf_pkg::MAG_W] ^ dir[ax][sdpf_pkg::MAG_W]);
        end
      // Slope is negative: flip the sign
      sdpf_pkg::ST_T1:
        if (mul_done) t <= sdpf_pkg::with_sign(sdpf_pkg::qprod(mul_p), !t[sdpf_pkg::MAG_W]);
      sdpf_pkg::ST_T2:
        if (mul_done) t <= sdpf_pkg::with_sign(sdpf_pkg::qprod(mul_p), t[sdpf_pkg::MAG_W]);
      sdpf_pkg::ST_T3:
        if (div_done) begin
          frc[ax] <= sdpf_pkg::sat_add(frc[ax],
                       sdpf_pkg::with_sign(div_q, t[sdpf_pkg::MAG_W]));
        end
      sdpf_pkg::ST_ACC:
        if (div_done) begin
          accel[ax] <= sdpf_pkg::clamp32(
                         sdpf_pkg::with_sign(div_q, frc[ax][sdpf_pkg::MAG_W]));
        end
      default: ;
    endcase
  end

  // Result word
  assign particle_index = sdpf_pkg::PIDX_W'(i);
  assign density        = den_i;
  assign accel_x        = accel[0];
  assign accel_y        = accel[1];
  assign accel_z        = accel[2];
  assign last           = result_valid && last_i;

`ifndef ASSERT_OFF
  a_strobe_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe outside a compute run");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PARTICLES))
    else $error("particle count beyond capacity");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !busy)
    else $error("run did not end after final word");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_start, div_start, sqrt_start}))
    else $error("two arithmetic units launched at once");

  a_no_relaunch: assert property (@(posedge clk) disable iff (rst)
    (mul_start || div_start || sqrt_start) |=> !(mul_start || div_start || sqrt_start))
    else $error("unit launched on consecutive cycles");
`endif

endmodule

### hdl/sdpf_mul.sv
module sdpf_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  sdpf_pkg::mag_t  a,
  input  sdpf_pkg::mag_t  b,
  output logic            done,
  output sdpf_pkg::prod_t prod
);

  logic             run;
  logic [1:0]       stp;
  sdpf_pkg::mag_t   oa;
  sdpf_pkg::mag_t   ob;
  sdpf_pkg::prod_t  acc;
  logic [23:0]      pa;
  logic [23:0]      pb;
  logic [47:0]      pp;
  sdpf_pkg::prod_t  pp_sh;

  // Pick one 24x24 partial product per step
  assign pa = stp[0] ? oa[47:24] : oa[23:0];
  assign pb = stp[1] ? ob[47:24] : ob[23:0];
  assign pp = pa * pb;

  always_comb begin
    case (stp) inside
      2'd0:       pp_sh = {48'b0, pp};
      2'd1, 2'd2: pp_sh = {24'b0, pp, 24'b0};
      default:    pp_sh = {pp, 48'b0};
    endcase
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      stp  <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        stp <= 2'd0;
      end else if (run) begin
        stp <= stp + 2'd1;
        if (stp == 2'd3) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Accumulate partial products
  always_ff @(posedge clk) begin
    if (start) begin
      oa  <= a;
      ob  <= b;
      acc <= '0;
    end else if (run) begin
      acc <= acc + pp_sh;
    end
  end

  assign prod = acc;

endmodule

### hdl/sdpf_div.sv
module sdpf_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sdpf_pkg::mag_t num,
  input  sdpf_pkg::mag_t den,
  output logic           done,
  output sdpf_pkg::mag_t quo
);

  localparam int NW = sdpf_pkg::MAG_W + 16;

  logic                       run;
  logic [$clog2(NW)-1:0]      cnt;
  logic [NW-1:0]              nreg;
  logic [NW-1:0]              qreg;
  logic [sdpf_pkg::MAG_W-1:0] rem;
  sdpf_pkg::mag_t             dreg;
  logic                       dz;
  logic                       nz;
  logic [sdpf_pkg::MAG_W:0]   rem_sh;
  logic [sdpf_pkg::MAG_W:0]   rem_nx;
  logic                       ge;

  // One quotient bit per cycle
  assign rem_sh = {rem, nreg[NW-1]};
  assign ge     = rem_sh >= {1'b0, dreg};
  assign rem_nx = ge ? (rem_sh - {1'b0, dreg}) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(NW)'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= {num, 16'b0};
      qreg <= '0;
      rem  <= '0;
      dreg <= den;
      dz   <= (den == '0);
      nz   <= (num != '0);
    end else if (run) begin
      nreg <= {nreg[NW-2:0], 1'b0};
      qreg <= {qreg[NW-2:0], ge};
      rem  <= rem_nx[sdpf_pkg::MAG_W-1:0];
    end
  end

  // Saturate, and treat a zero divisor by the dividend
  always_comb begin
    if (dz) begin
      quo = nz ? sdpf_pkg::LIM : '0;
    end else if (|qreg[NW-1:sdpf_pkg::MAG_W-1]) begin
      quo = sdpf_pkg::LIM;
    end else begin
      quo = qreg[sdpf_pkg::MAG_W-1:0];
    end
  end

endmodule

### hdl/sdpf_sqrt.sv
module sdpf_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic        run;
  logic [4:0]  cnt;
  logic [63:0] xr;
  logic [33:0] rem;
  logic [35:0] rem_n;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  // One root bit per cycle
  assign rem_n = {rem, xr[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rem_n >= trial;
  assign diff  = rem_n - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      xr   <= {xr[61:0], 2'b00};
      rem  <= ge ? diff[33:0] : rem_n[33:0];
      root <= {root[30:0], ge};
    end
  end

endmodule

### dv/tb_sph_density_pressure_force_core.sv
module tb_sph_density_pressure_force_core;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint unsigned SAT_MAG = 64'd1 << 47;
  localparam longint FX_ONE = 65536;
  localparam longint C6PI = 125165;
  localparam longint C12PI = 250329;
  localparam int SLOTS = 64;

  typedef struct packed {
    logic [5:0]  idx;
    logic [30:0] dens;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic        lst;
  } particle_word_t;

  typedef struct {
    logic [1:0]     act;
    logic [31:0]    x;
    logic [31:0]    y;
    logic [31:0]    z;
    logic [30:0]    m;
    bit             typed;
    particle_word_t word;
  } cmd_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0] particle_mass;
  logic result_valid;
  logic [5:0] particle_index;
  logic [30:0] density;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] accel_z;
  logic last;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sph_density_pressure_force_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .particle_mass(particle_mass),
    .result_valid(result_valid), .particle_index(particle_index), .density(density),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Model state of the particle store and registers
  logic [30:0] cfg_radius;
  logic [30:0] cfg_target;
  logic [30:0] cfg_gain;
  logic [31:0] sx [SLOTS];
  logic [31:0] sy [SLOTS];
  logic [31:0] sz [SLOTS];
  logic [30:0] smass [SLOTS];
  logic [30:0] sdens [SLOTS];
  int unsigned loaded;

  particle_word_t pending_particles[$];
  int errors;
  bit quiet_phase;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned fx_mag(longint a);
    longint unsigned u;
    u = a < 0 ? longint'(-a) : longint'(a);
    return u > SAT_MAG ? SAT_MAG : u;
  endfunction

  function automatic longint fx_signed(longint unsigned m, bit neg);
    if (m > SAT_MAG) m = SAT_MAG;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    longint unsigned m;
    p = 128'(fx_mag(a)) * 128'(fx_mag(b));
    m = (p > (128'd1 << 63)) ? SAT_MAG : 64'(p >> 16);
    return fx_signed(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned m;
    ua = fx_mag(a);
    ub = fx_mag(b);
    if (ub == 0) m = (ua != 0) ? SAT_MAG : 0;
    else m = (ua << 16) / ub;
    return fx_signed(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_sat(longint a);
    if (a > longint'(SAT_MAG)) return longint'(SAT_MAG);
    if (a < -longint'(SAT_MAG)) return -longint'(SAT_MAG);
    return a;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Offset of particle a from b; report whether b lies within the radius
  function automatic bit near_pair(int a, int b, output longint off[3], output longint d);
    longint r;
    longint unsigned sum;
    longint unsigned u;
    r = longint'(cfg_radius);
    sum = 0;
    d = 0;
    off[0] = longint'($signed(sx[a])) - longint'($signed(sx[b]));
    off[1] = longint'($signed(sy[a])) - longint'($signed(sy[b]));
    off[2] = longint'($signed(sz[a])) - longint'($signed(sz[b]));
    for (int k = 0; k < 3; k++) begin
      u = off[k] < 0 ? longint'(-off[k]) : longint'(off[k]);
      if (u >= longint'(r)) return 1'b0;
      sum += u * u;
    end
    if (sum >= longint'(r) * longint'(r)) return 1'b0;
    d = longint'(floor_sqrt(sum));
    return 1'b1;
  endfunction

  function automatic longint pressure(int i);
    return fx_mul(longint'(sdens[i]) - longint'(cfg_target), longint'(cfg_gain));
  endfunction

  // Run both passes and queue one word per loaded particle
  task automatic run_sph();
    longint r;
    longint off[3];
    longint dir[3];
    longint frc_sum[3];
    longint d;
    longint q;
    longint slope;
    longint shared;
    longint t;
    longint pi_i;
    longint a;
    longint unsigned acc;
    particle_word_t w;
    logic [31:0] ac [3];
    r = longint'(cfg_radius);
    for (int i = 0; i < loaded; i++) begin
      acc = 0;
      for (int j = 0; j < loaded; j++) begin
        if (!near_pair(i, j, off, d)) continue;
        q = ((r - d) << 16) / r;
        acc += longint'(fx_div(fx_div(fx_mul(C6PI, fx_mul(q, q)), r), r));
      end
      sdens[i] = acc > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : acc[30:0];
    end
    for (int i = 0; i < loaded; i++) begin
      frc_sum = '{0, 0, 0};
      pi_i = pressure(i);
      for (int j = 0; j < loaded; j++) begin
        if (j == i || !near_pair(i, j, off, d)) continue;
        if (d == 0) begin
          dir = '{0, FX_ONE, 0};
        end else begin
          for (int c = 0; c < 3; c++) dir[c] = fx_div(off[c], d);
        end
        q = ((r - d) << 16) / r;
        slope = -fx_div(fx_div(fx_div(fx_mul(C12PI, q), r), r), r);
        shared = (pi_i + pressure(j)) / 2;
        for (int c = 0; c < 3; c++) begin
          t = fx_mul(fx_mul(fx_mul(shared, dir[c]), slope), longint'(smass[j]));
          t = fx_div(t, longint'(sdens[j]));
          frc_sum[c] = fx_sat(frc_sum[c] + t);
        end
      end
      for (int c = 0; c < 3; c++) begin
        a = fx_div(frc_sum[c], longint'(sdens[i]));
        if (a > 64'sd2147483647) a = 64'sd2147483647;
        if (a < -64'sd2147483648) a = -64'sd2147483648;
        ac[c] = a[31:0];
      end
      w.idx = i[5:0];
      w.dens = sdens[i];
      w.ax = ac[0];
      w.ay = ac[1];
      w.az = ac[2];
      w.lst = (i + 1 == loaded);
      pending_particles.push_back(w);
    end
  endtask

  task automatic model_step(logic [1:0] act, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z, logic [30:0] m);
    case (act)
      sdpf_pkg::ACT_LOAD: begin
        if (loaded < SLOTS) begin
          sx[loaded] = x;
          sy[loaded] = y;
          sz[loaded] = z;
          smass[loaded] = m;
          loaded++;
        end
      end
      sdpf_pkg::ACT_CLEAR: loaded = 0;
      sdpf_pkg::ACT_COMPUTE: run_sph();
      default: ;
    endcase
  endtask

  task automatic idle_gap();
    int g;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_phase || pick < 70) g = 0;
    else if (pick < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    if (g > 0) begin
      start = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Present one command word and hold it until the block takes it
  task automatic send_cmd(logic [1:0] act, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic [30:0] m);
    idle_gap();
    action = act;
    pos_x = x;
    pos_y = y;
    pos_z = z;
    particle_mass = m;
    start = 1'b1;
    do @(posedge clk); while (busy);
    model_step(act, x, y, z, m);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Wait until every expected word is out and the block is idle
  task automatic drain();
    start = 1'b0;
    while (pending_particles.size() != 0) @(negedge clk);
    do @(negedge clk); while (busy);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(sdpf_pkg::reg_idx_t idx, logic [30:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 4'(idx) << 2;
    pwdata = {1'b0, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      sdpf_pkg::REG_RADIUS: cfg_radius = val;
      sdpf_pkg::REG_TARGET: cfg_target = val;
      default: cfg_gain = val;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(logic [30:0] r, logic [30:0] tg, logic [30:0] g);
    reg_write(sdpf_pkg::REG_RADIUS, r);
    reg_write(sdpf_pkg::REG_TARGET, tg);
    reg_write(sdpf_pkg::REG_GAIN, g);
  endtask

  // One well-formed run: clear, load a tight cluster, compute
  task automatic cluster_run(int n);
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    int span;
    span = int'(cfg_radius > 31'd4 ? cfg_radius / 2 : 1);
    if (span > 32'h3FFF_FFFF) span = 32'h3FFF_FFFF;
    cx = $urandom;
    cy = $urandom;
    cz = $urandom;
    send_cmd(sdpf_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, 31'($urandom));
    for (int k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 7) == 0) begin
        send_cmd(sdpf_pkg::ACT_LOAD, cx, cy, cz, 31'($urandom));
      end else begin
        send_cmd(sdpf_pkg::ACT_LOAD,
                 cx + 32'($urandom_range(0, span)) - 32'(span / 2),
                 cy + 32'($urandom_range(0, span)) - 32'(span / 2),
                 cz + 32'($urandom_range(0, span)) - 32'(span / 2),
                 $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 18)));
      end
    end
    send_cmd(sdpf_pkg::ACT_COMPUTE, $urandom, $urandom, $urandom, 31'($urandom));
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    particle_word_t want;
    if (!rst && result_valid) begin
      if (pending_particles.size() == 0) begin
        $display("%0t: unexpected word idx=%0d", $time, particle_index);
        errors++;
      end else begin
        want = pending_particles.pop_front();
        if (want.idx !== particle_index) begin
          $display("%0t: particle_index exp %0d got %0d", $time, want.idx, particle_index);
          errors++;
        end
        if (want.dens !== density) begin
          $display("%0t: density exp %h got %h", $time, want.dens, density);
          errors++;
        end
        if (want.ax !== accel_x) begin
          $display("%0t: accel_x exp %h got %h", $time, want.ax, accel_x);
          errors++;
        end
        if (want.ay !== accel_y) begin
          $display("%0t: accel_y exp %h got %h", $time, want.ay, accel_y);
          errors++;
        end
        if (want.az !== accel_z) begin
          $display("%0t: accel_z exp %h got %h", $time, want.az, accel_z);
          errors++;
        end
        if (want.lst !== last) begin
          $display("%0t: last exp %0d got %0d", $time, want.lst, last);
          errors++;
        end
      end
    end
  end

  initial begin
    cmd_row_t rows[$];
    cmd_row_t row;
    logic [30:0] rr;
    errors = 0;
    quiet_phase = 1'b0;
    loaded = 0;
    cfg_radius = 31'd65536;
    cfg_target = 31'd65536;
    cfg_gain = 31'd65536;
    rst = 1'b1;
    start = 1'b0;
    action = sdpf_pkg::ACT_LOAD;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    particle_mass = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, reset register values
    row = '{sdpf_pkg::ACT_COMPUTE, 0, 0, 0, 0, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_LOAD, 0, 0, 0, 31'd65536, 1'b0, '0};
    rows.push_back(row);
    // Lone particle at rest: self kernel only, no force
    row = '{sdpf_pkg::ACT_COMPUTE, 0, 0, 0, 0, 1'b1,
            '{6'd0, 31'd125165, 0, 0, 0, 1'b1}};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_LOAD, 0, 0, 0, 31'd0, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_LOAD, 32'h0000_8000, 32'hFFFF_C000, 32'h0000_2000,
            31'h7FFF_FFFF, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
            31'd1, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
            31'h7FFF_FFFF, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_COMPUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            31'h7FFF_FFFF, 1'b0, '0};
    rows.push_back(row);
    row = '{ACT_UNUSED, 0, 0, 0, 0, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_CLEAR, 0, 0, 0, 0, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_COMPUTE, 0, 0, 0, 0, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_LOAD, 32'h0001_0000, 0, 0, 31'd65536, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_LOAD, 32'h0001_4000, 32'h0000_1000, 0, 31'd131072, 1'b0, '0};
    rows.push_back(row);
    row = '{sdpf_pkg::ACT_COMPUTE, 0, 0, 0, 0, 1'b0, '0};
    rows.push_back(row);
    foreach (rows[i]) begin
      send_cmd(rows[i].act, rows[i].x, rows[i].y, rows[i].z, rows[i].m);
      if (rows[i].typed) begin
        void'(pending_particles.pop_back());
        pending_particles.push_back(rows[i].word);
      end
    end
    drain();

    // Fill the store, overfill it, then compute with far-apart particles
    set_config(31'd65536, 31'd0, 31'd65536);
    send_cmd(sdpf_pkg::ACT_CLEAR, 0, 0, 0, 0);
    for (int k = 0; k < SLOTS + 2; k++) begin
      send_cmd(sdpf_pkg::ACT_LOAD, 32'(k) << 18, 32'(k % 3) << 18, $urandom_range(0, 255),
               31'($urandom));
    end
    send_cmd(sdpf_pkg::ACT_COMPUTE, 0, 0, 0, 0);
    drain();

    // Register settings, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(31'd1, 31'd0, 31'd0);
        1: set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        2: set_config(31'd65536, 31'd0, 31'h7FFF_FFFF);
        3: set_config(31'd16, 31'h7FFF_FFFF, 31'd65536);
        default: begin
          rr = 31'($urandom_range(1 << 12, 1 << 22));
          set_config(rr, 31'($urandom_range(0, 1 << 20)), 31'($urandom));
        end
      endcase
      quiet_phase = (ph % 3 == 2);
      for (int s = 0; s < 12; s++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: stray or unused commands
          send_cmd($urandom_range(0, 1) ? ACT_UNUSED : sdpf_pkg::ACT_LOAD, $urandom,
                   $urandom, $urandom, 31'($urandom));
        end else begin
          cluster_run($urandom_range(1, 4));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/sdpf_pkg.sv
hdl/sdpf_mul.sv
hdl/sdpf_div.sv
hdl/sdpf_sqrt.sv
hdl/sph_density_pressure_force_core.sv
dv/tb_sph_density_pressure_force_core.sv
